@@ rtl/core/feso_pkg.sv @@
package feso_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int DELAY_W    = 16;
  localparam int FRAC_W     = 15;
  localparam int POS_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_DELAY_DEFAULT = 65536;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = sample_t'(16'h7FFF);
  localparam sample_t SAMPLE_MIN = sample_t'(16'h8000);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL = CFG_IDX_W'(1);

  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(1000);
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(16384);

  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef struct packed {
    logic echo_on;
    logic zero_delay;
    logic fwd;
  } mix_ctl_t;

endpackage

@@ rtl/core/feso_in_if.sv @@
interface feso_in_if import feso_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

@@ rtl/core/feso_out_if.sv @@
interface feso_out_if import feso_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    last_out;

  modport source (output valid, output sample_out, output last_out, input ready);
  modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

@@ rtl/core/feedback_echo_saturating_unit.sv @@
// Saturating feedback echo for a stream of signed 16-bit samples: one sample in, one sample
// out, at a sustained rate of one sample per clock cycle while the output side is ready. A
// sample accepted at the input is registered into the mixing stage and mixed there, and its
// result is loaded into the output register once that register is empty or is being read. A
// stalled output holds one result in the output register and one sample in the mixing stage
// before the input stalls. Past outputs live in a ring of MAX_DELAY 16-bit entries in one
// synchronous memory with one write and one read port; each sample reads its echo tap when it
// is accepted and writes its own result back as it moves to the output register, and a bypass
// register carries that result straight to the next sample when the delay is one. The ring
// is not cleared after reset, so a clip must be at least as long as the delay before the
// echo taps old data. Delays of MAX_DELAY or more are clamped to MAX_DELAY-1, and the
// position within a clip restarts after a sample marked last.
module feedback_echo_saturating_unit import feso_pkg::*; #(
  parameter int MAX_DELAY = MAX_DELAY_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  feso_in_if.sink               din,
  feso_out_if.source            dout,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int CW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;

  logic [DELAY_W-1:0] delay_samples;
  logic [LEVEL_W-1:0] echo_level;
  logic [AW-1:0]      wp;
  logic [AW-1:0]      wp_next;
  logic [POS_W-1:0]   pos;

  logic               s1_valid;
  sample_t            s1_x;
  logic               s1_last;
  mix_ctl_t           s1_ctl;
  logic [AW-1:0]      s1_wp;

  sample_t            y_prev;
  sample_t            mem_q;
  sample_t            mix_y;

  logic               out_valid;
  sample_t            out_sample;
  logic               out_last;

  logic               out_adv;
  logic               s1_adv;
  logic               in_acc;
  logic [CW-1:0]      d_ext;
  logic [CW-1:0]      d_eff;
  logic [CW-1:0]      wp_ext;
  logic [CW-1:0]      rd_full;
  logic [AW-1:0]      rd_addr;
  mix_ctl_t           ctl_in;

  assign out_adv   = !out_valid || dout.ready;
  assign s1_adv    = s1_valid && out_adv;
  assign din.ready = !s1_valid || out_adv;
  assign in_acc    = din.valid && din.ready;

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_sample;
  assign dout.last_out   = out_last;

  always_comb begin
    d_ext   = CW'(delay_samples);
    d_eff   = (d_ext > CW'(MAX_DELAY - 1)) ? CW'(MAX_DELAY - 1) : d_ext;
    wp_ext  = CW'(wp);
    rd_full = (wp_ext >= d_eff) ? wp_ext - d_eff : wp_ext + CW'(MAX_DELAY) - d_eff;
    rd_addr = rd_full[AW-1:0];
    wp_next = (wp == AW'(MAX_DELAY - 1)) ? '0 : wp + 1'b1;

    ctl_in.echo_on    = CW'(pos) >= d_eff;
    ctl_in.zero_delay = d_eff == '0;
    // The sample ahead writes the very entry being read in this cycle.
    ctl_in.fwd        = s1_adv && (s1_wp == rd_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= DELAY_RESET;
      echo_level    <= LEVEL_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DELAY: delay_samples <= cfg_data;
        REG_LEVEL: echo_level    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      pos      <= '0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        wp <= wp_next;
        if (din.last_in) begin
          pos <= '0;
        end else if (pos != POS_MAX) begin
          pos <= pos + 1'b1;
        end
      end
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x    <= din.sample_in;
      s1_last <= din.last_in;
      s1_ctl  <= ctl_in;
      s1_wp   <= wp;
    end
    if (s1_adv) begin
      y_prev     <= mix_y;
      out_sample <= mix_y;
      out_last   <= s1_last;
    end
  end

  feso_ring #(
    .DEPTH (MAX_DELAY),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_wp),
    .wr_data (mix_y),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (mem_q)
  );

  feso_mix u_mix (
    .x        (s1_x),
    .past_mem (mem_q),
    .past_fwd (y_prev),
    .level    (echo_level),
    .ctl      (s1_ctl),
    .y        (mix_y)
  );

endmodule

@@ rtl/core/feso_ring.sv @@
module feso_ring import feso_pkg::*; #(
  parameter int DEPTH = MAX_DELAY_DEFAULT,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  sample_t       wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output sample_t       rd_data
);

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is registered and held until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/feso_mix.sv @@
module feso_mix import feso_pkg::*; (
  input  sample_t              x,
  input  sample_t              past_mem,
  input  sample_t              past_fwd,
  input  logic [LEVEL_W-1:0]   level,
  input  mix_ctl_t             ctl,
  output sample_t              y
);

  localparam int MAG_W  = SAMPLE_W + 1;
  localparam int PROD_W = MAG_W + LEVEL_W;
  localparam int Q_W    = PROD_W - FRAC_W;
  localparam int SUM_W  = Q_W + 1;

  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(SAMPLE_MAX);
  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(SAMPLE_MIN);

  sample_t                   past;
  logic signed [MAG_W-1:0]   past_ext;
  logic [MAG_W-1:0]          mag;
  logic [PROD_W-1:0]         prod;
  logic [Q_W-1:0]            q;
  logic signed [SUM_W-1:0]   term;
  logic signed [SUM_W-1:0]   sum;

  always_comb begin
    priority if (ctl.zero_delay) begin
      past = x;
    end else if (ctl.fwd) begin
      past = past_fwd;
    end else begin
      past = past_mem;
    end

    // Scale the magnitude so that the product truncates toward zero.
    past_ext = MAG_W'(past);
    mag      = past[SAMPLE_W-1] ? MAG_W'(-past_ext) : MAG_W'(past_ext);
    prod     = PROD_W'(mag) * PROD_W'(level);
    q        = prod[PROD_W-1:FRAC_W];
    term     = past[SAMPLE_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    sum      = SUM_W'(x) + term;

    if (!ctl.echo_on) begin
      y = x;
    end else if (sum > SUM_HI) begin
      y = SAMPLE_MAX;
    end else if (sum < SUM_LO) begin
      y = SAMPLE_MIN;
    end else begin
      y = sample_t'(sum[SAMPLE_W-1:0]);
    end
  end

endmodule

@@ rtl/core/feso_checker.sv @@
module feso_checker import feso_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    din_valid,
  input logic    din_ready,
  input logic    dout_valid,
  input logic    dout_ready,
  input sample_t dout_sample,
  input logic    dout_last
);

  // The output side is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !dout_valid)
    else $error("output valid after reset");

  // A waiting result keeps its place and its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (dout_valid && !dout_ready) |=> (dout_valid && $stable(dout_sample) && $stable(dout_last)))
    else $error("output transaction changed while stalled");

  // A result only appears when an input transaction lies behind it, with the mixing stage between the two.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(dout_valid) |-> $past(din_valid && din_ready, 2))
    else $error("output without a matching input transaction");

  // With the output side draining, the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    dout_ready |-> din_ready)
    else $error("input stalled while output was ready");

endmodule

bind feedback_echo_saturating_unit feso_checker u_feso_checker (
  .clk         (clk),
  .rst         (rst),
  .din_valid   (din.valid),
  .din_ready   (din.ready),
  .dout_valid  (dout.valid),
  .dout_ready  (dout.ready),
  .dout_sample (dout.sample_out),
  .dout_last   (dout.last_out)
);
